// File: hdl/mspb_pkg.sv
// Shared types and constants for the masked 1bpp sprite line blitter.
// No dependencies; used by the front end, the back end and the top level.
package mspb_pkg;

    // Item operations
    typedef enum logic [1:0] {
        OP_BLIT      = 2'd0,
        OP_BLIT_SAVE = 2'd1,
        OP_RESTORE   = 2'd2,
        OP_READ      = 2'd3
    } opcode_t;

    localparam int SAVE_SLOTS = 8;
    localparam int SLOT_W     = 3;

    // Decoded line command, everything but the byte offset (its width
    // follows the screen size)
    typedef struct packed {
        opcode_t            op;
        logic [2:0]         bit_ofs;
        logic [7:0]         bmp;
        logic [7:0]         msk;
        logic [SLOT_W-1:0]  slot;
    } cmd_t;

endpackage

// File: hdl/mspb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mspb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/mspb_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
// No package dependencies; the payload is an opaque vector.
module mspb_cmd_fifo #(
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wptr_reg, wptr_next;
    logic              rptr_reg, rptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and fill count update
    always_comb
    begin
        wptr_next  = wptr_reg ^ do_push;
        rptr_next  = rptr_reg ^ do_pop;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/mspb_front.sv
// Front end: takes input items, forms the pixel index, byte and bit offsets.
// Depends on mspb_pkg (opcode_t, cmd_t).
module mspb_front #(
    parameter int SCREEN_WIDTH = 384,
    localparam int PIX_W  = $clog2(255 * SCREEN_WIDTH + 511 + 1),
    localparam int BOFF_W = PIX_W - 3
) (
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           opcode,
    input  logic [8:0]           x_pixel,
    input  logic [7:0]           y_row,
    input  logic [7:0]           bitmap_byte,
    input  logic [7:0]           mask_byte,
    input  logic [2:0]           slot,
    input  logic                 clearing,
    input  logic                 q_full,
    output logic                 q_push,
    output mspb_pkg::cmd_t       q_cmd,
    output logic [BOFF_W-1:0]    q_boff
);

    logic [PIX_W-1:0] pix;

    // Linear pixel index
    assign pix = PIX_W'(y_row) * PIX_W'(SCREEN_WIDTH) + PIX_W'(x_pixel);

    // No items while the frame store is being cleared
    assign full   = q_full || clearing;
    assign q_push = push && !full;

    assign q_boff        = pix[PIX_W-1:3];
    assign q_cmd.op      = mspb_pkg::opcode_t'(opcode);
    assign q_cmd.bit_ofs = pix[2:0];
    assign q_cmd.bmp     = bitmap_byte;
    assign q_cmd.msk     = mask_byte;
    assign q_cmd.slot    = slot;

endmodule

// File: hdl/mspb_back.sv
// Back end: clears the frame store after reset, then runs each line command
// as a two-byte read-modify-write, a read as reads only. Depends on mspb_pkg and mspb_ram.
module mspb_back #(
    parameter int SCREEN_WIDTH  = 384,
    parameter int SCREEN_HEIGHT = 216,
    localparam int PIX_W       = $clog2(255 * SCREEN_WIDTH + 511 + 1),
    localparam int BOFF_W      = PIX_W - 3,
    localparam int STORE_DEPTH = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8 + 1,
    localparam int AW          = $clog2(STORE_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mspb_pkg::cmd_t     q_cmd,
    input  logic [BOFF_W-1:0]  q_boff,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               clearing,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        old_word,
    output logic [7:0]         read_byte
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_LO,
        ST_MERGE,
        ST_WRITE,
        ST_WR_LO
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    mspb_pkg::cmd_t     cmd_reg, cmd_next;
    logic [BOFF_W-1:0]  boff_reg, boff_next;
    logic [7:0]         hi_reg, hi_next;
    logic [7:0]         lo_reg, lo_next;
    logic [7:0]         newlo_reg, newlo_next;
    logic [15:0]        saved_reg [mspb_pkg::SAVE_SLOTS];
    logic [15:0]        saved_next [mspb_pkg::SAVE_SLOTS];
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        old_word_reg, old_word_next;
    logic [7:0]         read_byte_reg, read_byte_next;

    logic [BOFF_W:0]    boff_lo;
    logic               hi_ok, lo_ok;
    logic [15:0]        word, mask_w, bmp_w, new_w;
    logic               out_free;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [7:0]         ram_wdata, ram_rdata;

    mspb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Bounds of the two bytes; bytes past the store read as zero
    assign boff_lo = {1'b0, boff_reg} + (BOFF_W+1)'(1);
    assign hi_ok   = 32'(boff_reg) < STORE_DEPTH;
    assign lo_ok   = 32'(boff_lo) < STORE_DEPTH;

    // Masked merge of the fetched word, or the saved word for a restore
    assign word   = {hi_reg, lo_reg};
    assign mask_w = {cmd_reg.msk, 8'h00} >> cmd_reg.bit_ofs;
    assign bmp_w  = {cmd_reg.bmp, 8'h00} >> cmd_reg.bit_ofs;
    assign new_w  = (cmd_reg.op == mspb_pkg::OP_RESTORE) ? saved_reg[cmd_reg.slot]
                                                         : ((word & ~mask_w) | bmp_w);

    assign out_free  = !out_valid_reg || pop;
    assign clearing  = (state_reg == ST_CLEAR);
    assign empty     = !out_valid_reg;
    assign old_word  = old_word_reg;
    assign read_byte = read_byte_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_next       = cmd_reg;
        boff_next      = boff_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        newlo_next     = newlo_reg;
        saved_next     = saved_reg;
        out_valid_next = out_valid_reg && !pop;
        old_word_next  = old_word_reg;
        read_byte_next = read_byte_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = AW'(boff_reg);
        ram_wdata      = new_w[15:8];
        ram_raddr      = AW'(boff_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 8'h00;
                if (32'(clr_cnt_reg) == STORE_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                ram_raddr = AW'(q_boff);
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    boff_next  = q_boff;
                    state_next = ST_RD_LO;
                end
            end
            ST_RD_LO:
            begin
                ram_raddr  = AW'(boff_lo);
                hi_next    = hi_ok ? ram_rdata : 8'h00;
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                lo_next    = lo_ok ? ram_rdata : 8'h00;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (cmd_reg.op == mspb_pkg::OP_READ)
                    begin
                        old_word_next  = 16'h0000;
                        read_byte_next = hi_reg;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        old_word_next  = word;
                        read_byte_next = 8'h00;
                        ram_we         = hi_ok;
                        newlo_next     = new_w[7:0];
                        if (cmd_reg.op == mspb_pkg::OP_BLIT_SAVE)
                        begin
                            saved_next[cmd_reg.slot] = word;
                        end
                        state_next = ST_WR_LO;
                    end
                end
            end
            ST_WR_LO:
            begin
                ram_we     = lo_ok;
                ram_waddr  = AW'(boff_lo);
                ram_wdata  = newlo_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < mspb_pkg::SAVE_SLOTS; i++)
            begin
                saved_reg[i] <= 16'h0000;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            saved_reg     <= saved_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        boff_reg      <= boff_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
        newlo_reg     <= newlo_next;
        old_word_reg  <= old_word_next;
        read_byte_reg <= read_byte_next;
    end

endmodule

// File: hdl/masked_sprite_blitter_1bpp_unit.sv
// Masked 1bpp sprite line blitter, top level. Depends on mspb_pkg,
// mspb_front, mspb_cmd_fifo and mspb_back (which holds the frame store RAM).
//
// After reset the block zeroes its frame store, one byte per cycle, all
// (SCREEN_WIDTH*SCREEN_HEIGHT+7)/8+1 bytes (10369 at 384x216); full stays
// high until then. Each item is one sprite line: the front end computes the
// byte and bit offsets and queues the command in a two-entry queue, and the
// back end reads the two bytes, and for all but a byte read writes them back,
// on the single-write, single-read frame store. A blit or restore runs as two
// reads, merge and two writes, a byte read as the two reads alone; results
// wait in an output register while the queue keeps taking items.
module masked_sprite_blitter_1bpp_unit #(
    parameter int SCREEN_WIDTH  = 384,
    parameter int SCREEN_HEIGHT = 216
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [8:0]  x_pixel,
    input  logic [7:0]  y_row,
    input  logic [7:0]  bitmap_byte,
    input  logic [7:0]  mask_byte,
    input  logic [2:0]  slot,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] old_word,
    output logic [7:0]  read_byte
);

    localparam int PIX_W  = $clog2(255 * SCREEN_WIDTH + 511 + 1);
    localparam int BOFF_W = PIX_W - 3;
    localparam int CMD_W  = $bits(mspb_pkg::cmd_t) + BOFF_W;

    logic               clearing;
    logic               q_full, q_empty, q_push, q_pop;
    mspb_pkg::cmd_t     f_cmd, b_cmd;
    logic [BOFF_W-1:0]  f_boff, b_boff;
    logic [CMD_W-1:0]   q_in, q_out;

    mspb_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_front (
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .x_pixel     (x_pixel),
        .y_row       (y_row),
        .bitmap_byte (bitmap_byte),
        .mask_byte   (mask_byte),
        .slot        (slot),
        .clearing    (clearing),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (f_cmd),
        .q_boff      (f_boff)
    );

    assign q_in = {f_cmd, f_boff};

    mspb_cmd_fifo #(
        .DATA_W (CMD_W)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign {b_cmd, b_boff} = q_out;

    mspb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (b_cmd),
        .q_boff    (b_boff),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .empty     (empty),
        .pop       (pop),
        .old_word  (old_word),
        .read_byte (read_byte)
    );

    // No item is taken while the store is being cleared
    a_no_push_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (full && !q_push))
        else $error("item accepted during frame store clear");

    // No result can exist before the clear pass ends
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (empty && q_empty))
        else $error("result or command present during frame store clear");

    // A result carries either a read byte or an old word, never both
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (old_word == 16'h0000 || read_byte == 8'h00))
        else $error("result has both old word and read byte");

endmodule
